/* src/avr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// avr_pkg
// Shared widths, codes, the CORDIC arctangent table and the record that
// travels down the chain of rotation cells.
// ----------------------------------------------------------------------------
package avr_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int ANGLE_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;

  // Internal binary angle is 32 bits wide; the top two bits pick a quadrant.
  localparam int TURN_W   = 32;
  localparam int RESID_W  = TURN_W - 2;
  // CORDIC datapath: Q1.30 values with headroom for growth and sign.
  localparam int CORDIC_W = 34;
  localparam int SHIFT_W  = $clog2(TURN_W);
  // Sine and cosine after clamping, Q1.30 in [-1, 1].
  localparam int TRIG_W   = 32;

  localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 652032874;
  localparam logic signed [CORDIC_W-1:0] ONE_Q30  = 1073741824;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_X = 2'd0;
  localparam kind_t KIND_Y = 2'd1;
  localparam kind_t KIND_Z = 2'd2;

  typedef logic [1:0] quad_t;
  localparam quad_t QUAD_FIRST  = 2'd0;
  localparam quad_t QUAD_SECOND = 2'd1;
  localparam quad_t QUAD_THIRD  = 2'd2;
  localparam quad_t QUAD_FOURTH = 2'd3;

  // atan(2^-i) in 32-bit binary angle units.
  localparam logic [TURN_W-1:0] ATAN_TABLE [TURN_W] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // One transaction as it moves from cell to cell.
  typedef struct packed {
    logic                              valid;
    kind_t                             kind;
    quad_t                             quad;
    logic signed [COORD_WIDTH-1:0]     vx;
    logic signed [COORD_WIDTH-1:0]     vy;
    logic signed [COORD_WIDTH-1:0]     vz;
    logic signed [CORDIC_W-1:0]        cx;
    logic signed [CORDIC_W-1:0]        cy;
    logic signed [CORDIC_W-1:0]        cz;
  } avr_stage_t;

endpackage
`default_nettype wire

/* src/avr_cordic_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// avr_cordic_cell
// One micro-rotation of the CORDIC, registered, with the vector carried along.
// ----------------------------------------------------------------------------
module avr_cordic_cell import avr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [SHIFT_W-1:0]   shift,
  input  logic [TURN_W-1:0]    atan_step,
  input  avr_stage_t           prev,
  output avr_stage_t           curr
);

  logic signed [CORDIC_W-1:0] x_in;
  logic signed [CORDIC_W-1:0] y_in;
  logic signed [CORDIC_W-1:0] z_in;
  logic signed [CORDIC_W-1:0] dx;
  logic signed [CORDIC_W-1:0] dy;
  logic signed [CORDIC_W-1:0] step;

  assign x_in = prev.cx;
  assign y_in = prev.cy;
  assign z_in = prev.cz;
  assign dx   = y_in >>> shift;
  assign dy   = x_in >>> shift;
  assign step = $signed({{(CORDIC_W-TURN_W){1'b0}}, atan_step});

  always_ff @(posedge clk) begin
    if (rst) begin
      curr.valid <= 1'b0;
    end else begin
      curr.valid <= prev.valid;
    end
    curr.kind <= prev.kind;
    curr.quad <= prev.quad;
    curr.vx   <= prev.vx;
    curr.vy   <= prev.vy;
    curr.vz   <= prev.vz;
    // Turn towards zero residual angle.
    if (!z_in[CORDIC_W-1]) begin
      curr.cx <= x_in - dx;
      curr.cy <= y_in + dy;
      curr.cz <= z_in - step;
    end else begin
      curr.cx <= x_in + dx;
      curr.cy <= y_in - dy;
      curr.cz <= z_in + step;
    end
  end

endmodule
`default_nettype wire

/* src/avr_plane_mix.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// avr_plane_mix
// Folds the CORDIC result into sine and cosine, applies the plane rotation
// with four multipliers, then rounds and saturates the two rotated components.
// ----------------------------------------------------------------------------
module avr_plane_mix import avr_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  avr_stage_t                    item,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z
);

  localparam int PROD_W = COORD_WIDTH + TRIG_W;
  localparam int MQ_W   = PROD_W - 16;
  localparam int SUM_W  = MQ_W + 1;
  localparam int RND_W  = SUM_W + 1 - 14;

  localparam logic signed [SUM_W:0]   ROUND_BIAS = 8192;
  localparam logic signed [RND_W-1:0] COORD_MAX  = (RND_W)'((64'd1 << (COORD_WIDTH - 1)) - 1);
  localparam logic signed [RND_W-1:0] COORD_MIN  = -COORD_MAX - 1;

  function automatic logic [COORD_WIDTH-1:0] sat_round(input logic signed [SUM_W-1:0] sum);
    logic signed [SUM_W:0]   biased;
    logic signed [RND_W-1:0] r;
    biased = $signed({sum[SUM_W-1], sum}) + ROUND_BIAS;
    r      = biased[SUM_W:14];
    if (r > COORD_MAX) begin
      sat_round = COORD_MAX[COORD_WIDTH-1:0];
    end else if (r < COORD_MIN) begin
      sat_round = COORD_MIN[COORD_WIDTH-1:0];
    end else begin
      sat_round = r[COORD_WIDTH-1:0];
    end
  endfunction

  // Stage A: clamp, quadrant fold and operand selection.
  logic signed [CORDIC_W-1:0]    cx_cl;
  logic signed [CORDIC_W-1:0]    cy_cl;
  logic signed [TRIG_W-1:0]      cos_next;
  logic signed [TRIG_W-1:0]      sin_next;
  logic signed [COORD_WIDTH-1:0] a_next;
  logic signed [COORD_WIDTH-1:0] b_next;

  logic                          a_valid;
  kind_t                         a_kind;
  logic signed [COORD_WIDTH-1:0] a_vx;
  logic signed [COORD_WIDTH-1:0] a_vy;
  logic signed [COORD_WIDTH-1:0] a_vz;
  logic signed [COORD_WIDTH-1:0] op_a;
  logic signed [COORD_WIDTH-1:0] op_b;
  logic signed [TRIG_W-1:0]      trig_c;
  logic signed [TRIG_W-1:0]      trig_s;

  always_comb begin
    if (item.cx > ONE_Q30) begin
      cx_cl = ONE_Q30;
    end else if (item.cx < -ONE_Q30) begin
      cx_cl = -ONE_Q30;
    end else begin
      cx_cl = item.cx;
    end
    if (item.cy > ONE_Q30) begin
      cy_cl = ONE_Q30;
    end else if (item.cy < -ONE_Q30) begin
      cy_cl = -ONE_Q30;
    end else begin
      cy_cl = item.cy;
    end
    case (item.quad)
      QUAD_SECOND: begin
        cos_next = TRIG_W'(-cy_cl);
        sin_next = TRIG_W'(cx_cl);
      end
      QUAD_THIRD: begin
        cos_next = TRIG_W'(-cx_cl);
        sin_next = TRIG_W'(-cy_cl);
      end
      QUAD_FOURTH: begin
        cos_next = TRIG_W'(cy_cl);
        sin_next = TRIG_W'(-cx_cl);
      end
      default: begin
        cos_next = TRIG_W'(cx_cl);
        sin_next = TRIG_W'(cy_cl);
      end
    endcase
    // The Y rotation takes a = x and b = z and flips the second output's form.
    case (item.kind)
      KIND_X: begin
        a_next = item.vy;
        b_next = item.vz;
      end
      KIND_Y: begin
        a_next = item.vx;
        b_next = item.vz;
      end
      default: begin
        a_next = item.vx;
        b_next = item.vy;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= item.valid;
    end
    a_kind <= item.kind;
    a_vx   <= item.vx;
    a_vy   <= item.vy;
    a_vz   <= item.vz;
    op_a   <= a_next;
    op_b   <= b_next;
    trig_c <= cos_next;
    trig_s <= sin_next;
  end

  // Stage B: four products, each floored to 2^-14 of the coordinate grid.
  logic signed [PROD_W-1:0]      prod_ac;
  logic signed [PROD_W-1:0]      prod_bs;
  logic signed [PROD_W-1:0]      prod_as;
  logic signed [PROD_W-1:0]      prod_bc;

  logic                          b_valid;
  kind_t                         b_kind;
  logic signed [COORD_WIDTH-1:0] b_vx;
  logic signed [COORD_WIDTH-1:0] b_vy;
  logic signed [COORD_WIDTH-1:0] b_vz;
  logic signed [MQ_W-1:0]        p_ac;
  logic signed [MQ_W-1:0]        p_bs;
  logic signed [MQ_W-1:0]        p_as;
  logic signed [MQ_W-1:0]        p_bc;

  assign prod_ac = PROD_W'(op_a) * PROD_W'(trig_c);
  assign prod_bs = PROD_W'(op_b) * PROD_W'(trig_s);
  assign prod_as = PROD_W'(op_a) * PROD_W'(trig_s);
  assign prod_bc = PROD_W'(op_b) * PROD_W'(trig_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_kind <= a_kind;
    b_vx   <= a_vx;
    b_vy   <= a_vy;
    b_vz   <= a_vz;
    p_ac   <= prod_ac[PROD_W-1:16];
    p_bs   <= prod_bs[PROD_W-1:16];
    p_as   <= prod_as[PROD_W-1:16];
    p_bc   <= prod_bc[PROD_W-1:16];
  end

  // Stage C: combine, round half up, saturate and place by axis.
  logic signed [SUM_W-1:0]       sum_one;
  logic signed [SUM_W-1:0]       sum_two;
  logic [COORD_WIDTH-1:0]        res_one;
  logic [COORD_WIDTH-1:0]        res_two;
  logic signed [COORD_WIDTH-1:0] x_next;
  logic signed [COORD_WIDTH-1:0] y_next;
  logic signed [COORD_WIDTH-1:0] z_next;

  always_comb begin
    sum_one = SUM_W'(p_ac) - SUM_W'(p_bs);
    if (b_kind == KIND_Y) begin
      sum_two = SUM_W'(p_bc) - SUM_W'(p_as);
    end else begin
      sum_two = SUM_W'(p_as) + SUM_W'(p_bc);
    end
    res_one = sat_round(sum_one);
    res_two = sat_round(sum_two);
    x_next  = b_vx;
    y_next  = b_vy;
    z_next  = b_vz;
    case (b_kind)
      KIND_X: begin
        y_next = res_one;
        z_next = res_two;
      end
      KIND_Y: begin
        x_next = res_one;
        z_next = res_two;
      end
      KIND_Z: begin
        x_next = res_one;
        y_next = res_two;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= b_valid;
    end
    out_x <= x_next;
    out_y <= y_next;
    out_z <= z_next;
  end

endmodule
`default_nettype wire

/* src/axis_vector_rotator_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// axis_vector_rotator_core
// Rotates a Q16.16 vector about the X, Y or Z axis by a binary angle.
// ----------------------------------------------------------------------------
// A transaction is offered by raising start with kind, in_x, in_y, in_z and
// turn_angle; it is taken at any rising edge where start is high and busy is
// low. busy is only high while rst is asserted, so a new transaction can be
// taken on every clock cycle.
// The angle is turned into sine and cosine by a row of CORDIC_STAGES
// identical cells, each doing one micro-rotation and passing its work to the
// next cell on every clock. Three further stages fold the quadrant, form the
// four products and then round and saturate the two rotated components.
// The axis component, and all three components for an unused kind, pass
// through unchanged.
// Each transaction passes through the CORDIC_STAGES cell registers and then
// the stage A, stage B and result registers; done is high for the one cycle
// that follows the loading of the result registers. Throughput is one
// transaction per clock, set by the fully pipelined cell row and multipliers.
// The receiver cannot stall the block, so each result is shown for exactly
// one cycle. Reset clears every valid flag in the pipeline; transactions in
// flight at reset are dropped and no result is produced for them.
// ----------------------------------------------------------------------------
module axis_vector_rotator_core import avr_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    kind,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  input  logic [ANGLE_WIDTH-1:0]        turn_angle,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z
);

  avr_stage_t        chain [CORDIC_STAGES+1];
  logic [TURN_W-1:0] angle_turn;

  assign busy = rst;

  // Spread the angle over a full 32-bit turn.
  assign angle_turn = {turn_angle, {(TURN_W-ANGLE_WIDTH){1'b0}}};

  always_comb begin
    chain[0].valid = start && !busy;
    chain[0].kind  = kind;
    chain[0].quad  = angle_turn[TURN_W-1 -: 2];
    chain[0].vx    = in_x;
    chain[0].vy    = in_y;
    chain[0].vz    = in_z;
    chain[0].cx    = GAIN_Q30;
    chain[0].cy    = '0;
    chain[0].cz    = $signed({{(CORDIC_W-RESID_W){1'b0}}, angle_turn[RESID_W-1:0]});
  end

  // The row of rotation cells; cell i shifts by i and uses atan(2^-i).
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    avr_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (SHIFT_W'(i)),
      .atan_step (ATAN_TABLE[i]),
      .prev      (chain[i]),
      .curr      (chain[i+1])
    );
  end

  avr_plane_mix u_mix (
    .clk   (clk),
    .rst   (rst),
    .item  (chain[CORDIC_STAGES]),
    .done  (done),
    .out_x (out_x),
    .out_y (out_y),
    .out_z (out_z)
  );

endmodule
`default_nettype wire

/* bench/axis_vector_rotator_core_tb.sv */
// ----------------------------------------------------------------------------
// axis_vector_rotator_core_tb
// Self-checking bench for the principal-axis vector rotator. Each vector is
// rotated here by a bit-exact copy of the fixed-point CORDIC arithmetic, and
// every done strobe is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module axis_vector_rotator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import avr_pkg::*;

  // The fourth kind code selects no axis at all.
  localparam kind_t KIND_NONE = 2'd3;

  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // CORDIC constants in Q1.30: the start value that cancels the gain, and one.
  localparam longint CORDIC_START = 652032874;
  localparam longint TRIG_ONE     = 1073741824;

  // Arctangent of 2^-i, in units where 2^32 is a full turn.
  localparam logic [31:0] ARCTAN_TURN [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  localparam int RANDOM_VECTORS = 1550;
  // The tail wait leaves ample margin over the pipeline depth.
  localparam int TAIL_CYCLES    = 3 * (CORDIC_STAGES + 2);

  // A vector waiting to be offered, with the idle time that precedes it.
  typedef struct {
    kind_t                         kind;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    logic [ANGLE_WIDTH-1:0]        angle;
    int                            idle_before;
    bit                            wait_drain;
  } vector_txn_t;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } rotated_t;

  logic                          clk;
  logic                          rst        = 1'b1;
  logic                          start      = 1'b0;
  logic                          busy;
  logic [1:0]                    kind       = '0;
  logic signed [COORD_WIDTH-1:0] in_x       = '0;
  logic signed [COORD_WIDTH-1:0] in_y       = '0;
  logic signed [COORD_WIDTH-1:0] in_z       = '0;
  logic [ANGLE_WIDTH-1:0]        turn_angle = '0;
  logic                          done;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;

  vector_txn_t pending_q [$];   // vectors not yet offered to the block
  rotated_t    rotated_q [$];   // predicted results, oldest first
  vector_txn_t offered;         // the vector currently on the input ports
  rotated_t    oldest;
  bit          holding   = 1'b0;
  bit          gap_armed = 1'b0;
  int          gap_left  = 0;
  int          n_sent    = 0;   // transactions accepted by the block
  int          n_seen    = 0;   // results observed; written only by the monitor
  int          n_err     = 0;

  axis_vector_rotator_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .in_x       (in_x),
    .in_y       (in_y),
    .in_z       (in_z),
    .turn_angle (turn_angle),
    .done       (done),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Sine and cosine in Q1.30. The top two angle bits choose the quadrant and
  // the CORDIC only ever sees the residue within the first quarter turn.
  function automatic void trig_of_angle(input logic [ANGLE_WIDTH-1:0] ang,
                                        output longint sn, output longint cs);
    logic [31:0] a32;
    quad_t       quad;
    longint      cx, cy, cz, dx, dy, step_ang;
    a32  = {ang, {(32-ANGLE_WIDTH){1'b0}}};
    quad = a32[31:30];
    cx   = CORDIC_START;
    cy   = 0;
    cz   = a32[29:0];
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      dx       = cy >>> i;
      dy       = cx >>> i;
      step_ang = ARCTAN_TURN[i];
      if (cz >= 0) begin
        cx -= dx;
        cy += dy;
        cz -= step_ang;
      end else begin
        cx += dx;
        cy -= dy;
        cz += step_ang;
      end
    end
    if (cx > TRIG_ONE) cx = TRIG_ONE;
    else if (cx < -TRIG_ONE) cx = -TRIG_ONE;
    if (cy > TRIG_ONE) cy = TRIG_ONE;
    else if (cy < -TRIG_ONE) cy = -TRIG_ONE;
    case (quad)
      QUAD_SECOND: begin
        cs = -cy;
        sn = cx;
      end
      QUAD_THIRD: begin
        cs = -cx;
        sn = -cy;
      end
      QUAD_FOURTH: begin
        cs = cy;
        sn = -cx;
      end
      default: begin
        cs = cx;
        sn = cy;
      end
    endcase
  endfunction

  // Coordinate times a Q1.30 value, kept at 2^-14 of the Q16.16 grid. The
  // trig value is split so that only the low half's fraction is floored.
  function automatic longint scaled_product(longint coord, longint trig);
    longint t_hi, t_lo;
    t_hi = trig >>> 16;
    t_lo = trig - t_hi * 65536;
    return coord * t_hi + ((coord * t_lo) >>> 16);
  endfunction

  // Round half up back to Q16.16 and clip to the coordinate range.
  function automatic logic signed [COORD_WIDTH-1:0] round_saturate(longint acc);
    longint r, hi, lo;
    hi = (longint'(1) <<< (COORD_WIDTH-1)) - 1;
    lo = -hi - 1;
    r  = (acc + 8192) >>> 14;
    if (r > hi) r = hi;
    else if (r < lo) r = lo;
    return r[COORD_WIDTH-1:0];
  endfunction

  function automatic rotated_t rotate_vector(vector_txn_t v);
    rotated_t r;
    longint   vx, vy, vz, sn, cs;
    vx = v.x;
    vy = v.y;
    vz = v.z;
    trig_of_angle(v.angle, sn, cs);
    r.x = v.x;
    r.y = v.y;
    r.z = v.z;
    case (v.kind)
      KIND_X: begin
        r.y = round_saturate(scaled_product(vy, cs) - scaled_product(vz, sn));
        r.z = round_saturate(scaled_product(vy, sn) + scaled_product(vz, cs));
      end
      KIND_Y: begin
        r.x = round_saturate(scaled_product(vx, cs) - scaled_product(vz, sn));
        r.z = round_saturate(scaled_product(vz, cs) - scaled_product(vx, sn));
      end
      KIND_Z: begin
        r.x = round_saturate(scaled_product(vx, cs) - scaled_product(vy, sn));
        r.y = round_saturate(scaled_product(vx, sn) + scaled_product(vy, cs));
      end
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic queue_vector(kind_t k, logic signed [COORD_WIDTH-1:0] x,
                              logic signed [COORD_WIDTH-1:0] y,
                              logic signed [COORD_WIDTH-1:0] z,
                              logic [ANGLE_WIDTH-1:0] ang, int idle, bit drain);
    vector_txn_t v;
    v.kind        = k;
    v.x           = x;
    v.y           = y;
    v.z           = z;
    v.angle       = ang;
    v.idle_before = idle;
    v.wait_drain  = drain;
    pending_q.push_back(v);
  endtask

  // Extremes and small magnitudes are over-represented so that saturation and
  // the fine rounding behaviour are both exercised often.
  function automatic logic signed [COORD_WIDTH-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return '0;
      3:       return $urandom_range(0, 1) ? 1 : -1;
      4, 5:    return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      default: return $urandom;
    endcase
  endfunction

  // One angle in four near an octant boundary, every other one a quadrant fold.
  function automatic logic [ANGLE_WIDTH-1:0] pick_angle();
    logic [ANGLE_WIDTH-1:0] base;
    base = {3'($urandom_range(0, 7)), {(ANGLE_WIDTH-3){1'b0}}};
    case ($urandom_range(0, 3))
      0:       return base + ANGLE_WIDTH'($urandom_range(0, 2)) - 1'b1;
      default: return ANGLE_WIDTH'($urandom);
    endcase
  endfunction

  function automatic kind_t pick_kind();
    if ($urandom_range(0, 9) == 0) return KIND_NONE;
    return kind_t'($urandom_range(0, 2));
  endfunction

  // Mostly back-to-back, sometimes a short gap, now and then a long one.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_mismatch(input string what, input logic signed [COORD_WIDTH-1:0] want_v,
                               input logic signed [COORD_WIDTH-1:0] got_v);
    // Only the first few are printed so that a broken block cannot flood the
    // log; every one of them is counted.
    if (n_err < 40)
      $display("%0t ns: %s: expected %0d, got %0d", $realtime, what, want_v, got_v);
    n_err++;
  endtask

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------
  // A transaction is taken at an edge where start is high and busy is low. At
  // that edge its prediction is queued. The next vector is then loaded once
  // its idle gap has run down, and a vector marked for draining is held back
  // until every earlier result has come out. start gets exactly one update
  // per edge, so a vector that follows directly keeps start high throughout.
  // While no vector is offered the data ports carry noise, which the block
  // must ignore.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        rotated_q.push_back(rotate_vector(offered));
        n_sent++;
        holding = 1'b0;
      end
      if (!holding && pending_q.size() > 0) begin
        if (!gap_armed) begin
          gap_left  = pending_q[0].idle_before;
          gap_armed = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!pending_q[0].wait_drain || n_seen >= n_sent) begin
          offered   = pending_q.pop_front();
          holding   = 1'b1;
          gap_armed = 1'b0;
        end
      end
      start <= holding;
      if (holding) begin
        kind       <= offered.kind;
        in_x       <= offered.x;
        in_y       <= offered.y;
        in_z       <= offered.z;
        turn_angle <= offered.angle;
      end else begin
        kind       <= 2'($urandom);
        in_x       <= $urandom;
        in_y       <= $urandom;
        in_z       <= $urandom;
        turn_angle <= ANGLE_WIDTH'($urandom);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor
  // --------------------------------------------------------------------------
  // done marks a result for exactly one cycle; it is taken at the edge that
  // ends that cycle. The result count is advanced with a nonblocking update so
  // that the driver always sees the value from before the edge.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (rotated_q.size() == 0) begin
        flag_mismatch("result with no transaction outstanding", '0, out_x);
      end else begin
        oldest = rotated_q.pop_front();
        if (out_x !== oldest.x) flag_mismatch("out_x", oldest.x, out_x);
        if (out_y !== oldest.y) flag_mismatch("out_y", oldest.y, out_y);
        if (out_z !== oldest.z) flag_mismatch("out_z", oldest.z, out_z);
      end
      n_seen <= n_seen + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    // Directed vectors: zero angle, quarter and half turns, the wrap at the
    // top of the angle range, the unused kind passing everything through,
    // and sums that overflow in both directions.
    queue_vector(KIND_X, '0, COORD_MAX, COORD_MIN, 16'h0000, 0, 1'b0);
    queue_vector(KIND_X, COORD_MAX, COORD_MAX, COORD_MAX, 16'h2000, 0, 1'b0);
    queue_vector(KIND_X, 1, -1, 1, 16'hFFFF, 0, 1'b0);
    queue_vector(KIND_X, COORD_MIN, COORD_MIN, COORD_MIN, 16'h8000, 0, 1'b0);
    queue_vector(KIND_Y, COORD_MAX, COORD_MIN, COORD_MAX, 16'h4000, 0, 1'b0);
    queue_vector(KIND_Y, COORD_MIN, COORD_MAX, COORD_MAX, 16'h2000, 0, 1'b0);
    queue_vector(KIND_Y, 32'h0001_0000, '0, '0, 16'h8000, 1, 1'b0);
    queue_vector(KIND_Y, COORD_MIN, 5, COORD_MIN, 16'h8000, 0, 1'b0);
    queue_vector(KIND_Z, COORD_MIN, COORD_MIN, '0, 16'h2000, 0, 1'b0);
    queue_vector(KIND_Z, 32'h0001_0000, '0, COORD_MAX, 16'hC000, 0, 1'b0);
    queue_vector(KIND_Z, COORD_MAX, COORD_MAX, COORD_MIN, 16'h6000, 2, 1'b0);
    queue_vector(KIND_Z, -1, 32'h0000_7FFF, 1, 16'h0001, 0, 1'b0);
    queue_vector(KIND_Z, COORD_MIN, COORD_MIN, 7, 16'h4000, 0, 1'b0);
    queue_vector(KIND_Z, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'hE000, 0, 1'b0);
    queue_vector(KIND_NONE, COORD_MAX, COORD_MIN, -1, 16'h1234, 0, 1'b0);
    queue_vector(KIND_NONE, COORD_MIN, COORD_MAX, '0, 16'hFFFF, 0, 1'b0);
    queue_vector(KIND_X, 32'h1234_5678, 32'h0ABC_DEF0, -32'sh0010_0000, 16'hA000, 5, 1'b0);

    // Random vectors. A stretch of 40 at the start of every block of 250
    // runs back-to-back, and a few vectors wait for the pipeline to empty.
    for (int n = 0; n < RANDOM_VECTORS; n++)
      queue_vector(pick_kind(), pick_coord(), pick_coord(), pick_coord(), pick_angle(),
                   (n % 250) < 40 ? 0 : pick_idle(), (n % 400) == 0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() > 0 || holding) @(posedge clk);
    while (n_seen < n_sent) @(posedge clk);
    // Any result arriving now would be one that nothing asked for.
    repeat (TAIL_CYCLES) @(posedge clk);

    if (n_err == 0)
      $display("axis_vector_rotator_core: match");
    else
      $display("axis_vector_rotator_core: mismatch");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, with every gap at its
  // longest and every drain waiting out the full pipeline.
  initial begin
    #5ms;
    $display("axis_vector_rotator_core: mismatch");
    $finish;
  end

endmodule

/* sim.f */
src/avr_pkg.sv
src/avr_cordic_cell.sv
src/avr_plane_mix.sv
src/axis_vector_rotator_core.sv
bench/axis_vector_rotator_core_tb.sv
